// File: hdl/ubag_pkg.sv
// ----------------------------------------------------------------------------
// ubag_pkg
// Shared types and constants for the bag core with sort and search.
// ----------------------------------------------------------------------------
package ubag_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_QUERY  = 3'd2,
        MODE_SORT   = 3'd3,
        MODE_SEARCH = 3'd4,
        MODE_CLEAR  = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_SCAN_CHK,
        ST_REM_RD,
        ST_REM_WT,
        ST_SORT_RD0,
        ST_SORT_RD1,
        ST_SORT_WT,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_BS_RD,
        ST_BS_WT,
        ST_BS_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                   op_ok;
        logic                   found;
        logic [IDX_W-1:0]       found_index;
        logic [CNT_W-1:0]       frequency;
        logic [CNT_W-1:0]       item_count;
        logic                   is_empty;
        logic                   is_sorted;
    } t_result;

endpackage

// File: hdl/ubag_if.sv
// ----------------------------------------------------------------------------
// ubag_in_if / ubag_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface ubag_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] item_value;
    modport source (output valid, mode, item_value, input ready);
    modport sink (input valid, mode, item_value, output ready);
endinterface

interface ubag_out_if;
    logic       valid;
    logic       ready;
    logic       op_ok;
    logic       found;
    logic [5:0] found_index;
    logic [6:0] frequency;
    logic [6:0] item_count;
    logic       is_empty;
    logic       is_sorted;
    modport source (output valid, op_ok, found, found_index, frequency, item_count,
                    is_empty, is_sorted, input ready);
    modport sink (input valid, op_ok, found, found_index, frequency, item_count,
                  is_empty, is_sorted, output ready);
endinterface

// File: hdl/unordered_bag_with_sort_and_search_core.sv
// Add and clear finish without a memory walk; query and remove read the stored entries in turn.
// Binary search reads one entry per halving step; sort reads, compares and may swap each adjacent pair,
// so its work grows quadratically with the entry count, set by the single memory port.
// One command is worked at a time; a finished result may wait while the next is taken.
// Synchronous active-low reset empties the bag and clears the sorted flag.
// ----------------------------------------------------------------------------
// unordered_bag_with_sort_and_search_core
// Top level: sequencer plus the entry memory.
// ----------------------------------------------------------------------------
module unordered_bag_with_sort_and_search_core import ubag_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ubag_in_if.sink     i_cmd,
    ubag_out_if.source  o_res
);
    logic                   w_we;
    logic [IDX_W-1:0]       w_addr;
    logic [VALUE_WIDTH-1:0] w_wdata, w_rdata;
    t_result                w_res;

    ubag_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    ubag_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_cmd.valid), .o_in_ready(i_cmd.ready),
        .i_mode(i_cmd.mode), .i_value(i_cmd.item_value[VALUE_WIDTH-1:0]),
        .o_res_valid(o_res.valid), .i_res_ready(o_res.ready), .o_res(w_res),
        .o_we(w_we), .o_addr(w_addr), .o_wdata(w_wdata), .i_rdata(w_rdata)
    );

    assign o_res.op_ok = w_res.op_ok;
    assign o_res.found = w_res.found;
    assign o_res.found_index = w_res.found_index;
    assign o_res.frequency = w_res.frequency;
    assign o_res.item_count = w_res.item_count;
    assign o_res.is_empty = w_res.is_empty;
    assign o_res.is_sorted = w_res.is_sorted;
endmodule

// File: hdl/ubag_ram.sv
// ----------------------------------------------------------------------------
// ubag_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ubag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hdl/ubag_ctrl.sv
// ----------------------------------------------------------------------------
// ubag_ctrl
// Sequencer that walks the entry memory for the remove, query, sort and search commands.
// ----------------------------------------------------------------------------
module ubag_ctrl import ubag_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_mode,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output t_result                o_res,
    output logic                   o_we,
    output logic [IDX_W-1:0]       o_addr,
    output logic [VALUE_WIDTH-1:0] o_wdata,
    input  logic [VALUE_WIDTH-1:0] i_rdata
);
    t_state r_state, n_state;
    logic [2:0]             r_mode;
    logic [VALUE_WIDTH-1:0] r_val, r_a;
    logic [CNT_W-1:0]       r_cnt, r_i, r_lim, r_lo, r_hi, r_freq, r_pos;
    logic                   r_sorted, r_fnd, r_swapped, r_ok;
    logic                   r_vld;
    t_result                r_res;
    logic [CNT_W-1:0]       w_mid;

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_vld;
    assign o_res = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    case (i_mode)
                        MODE_REMOVE, MODE_QUERY: n_state = ST_SCAN_RD;
                        MODE_SORT:   n_state = ST_SORT_RD0;
                        MODE_SEARCH: n_state = ST_BS_RD;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD:  n_state = (r_i >= r_cnt) ? ST_DONE : ST_SCAN_WT;
            ST_SCAN_WT:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (r_mode == MODE_REMOVE && i_rdata == r_val) begin
                    n_state = ST_REM_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_REM_RD:   n_state = ST_REM_WT;
            ST_REM_WT:   n_state = ST_DONE;
            ST_SORT_RD0: begin
                if (r_i + 1'b1 < r_lim) begin
                    n_state = ST_SORT_RD1;
                end else if (r_lim > CNT_W'(1) && r_swapped) begin
                    n_state = ST_SORT_RD0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SORT_RD1: n_state = ST_SORT_WT;
            ST_SORT_WT:  n_state = ST_SORT_CMP;
            ST_SORT_CMP: n_state = (r_a > i_rdata) ? ST_SORT_WR : ST_SORT_RD0;
            ST_SORT_WR:  n_state = ST_SORT_RD0;
            ST_BS_RD:    n_state = !r_sorted ? ST_DONE : (r_lo < r_hi) ? ST_BS_WT : ST_BS_CHK;
            ST_BS_WT:    n_state = ST_BS_RD;
            ST_BS_CHK:   n_state = ST_DONE;
            ST_DONE:     n_state = (!r_vld || i_res_ready) ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_we = 1'b0;
        o_addr = r_i[IDX_W-1:0];
        o_wdata = r_val;
        case (r_state)
            ST_IDLE:    o_addr = r_cnt[IDX_W-1:0];
            ST_SCAN_RD: o_addr = r_i[IDX_W-1:0];
            ST_REM_RD:  o_addr = IDX_W'(r_cnt - 1'b1);
            ST_REM_WT: begin
                o_we = 1'b1;
                o_addr = r_pos[IDX_W-1:0];
                o_wdata = i_rdata;
            end
            ST_SORT_RD0: o_addr = r_i[IDX_W-1:0];
            ST_SORT_RD1: o_addr = IDX_W'(r_i + 1'b1);
            ST_SORT_WT:  o_addr = IDX_W'(r_i + 1'b1);
            ST_SORT_CMP: begin
                o_we = r_a > i_rdata;
                o_addr = r_i[IDX_W-1:0];
                o_wdata = i_rdata;
            end
            ST_SORT_WR: begin
                o_we = 1'b1;
                o_addr = IDX_W'(r_i + 1'b1);
                o_wdata = r_a;
            end
            ST_BS_RD:  o_addr = (r_lo < r_hi) ? w_mid[IDX_W-1:0] : r_lo[IDX_W-1:0];
            ST_BS_CHK: o_addr = r_lo[IDX_W-1:0];
            default: ;
        endcase
        if (r_state == ST_IDLE && i_in_valid && o_in_ready && i_mode == MODE_ADD
            && r_cnt < CNT_W'(CAPACITY)) begin
            o_we = 1'b1;
            o_wdata = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_sorted <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_vld && i_res_ready && r_state != ST_DONE) begin
                r_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_mode <= i_mode;
                        r_val <= i_value;
                        r_i <= '0;
                        r_freq <= '0;
                        r_fnd <= 1'b0;
                        r_pos <= '0;
                        r_ok <= 1'b0;
                        r_lo <= '0;
                        r_hi <= r_cnt;
                        r_lim <= r_cnt;
                        r_swapped <= 1'b0;
                        case (i_mode)
                            MODE_ADD: begin
                                if (r_cnt < CNT_W'(CAPACITY)) begin
                                    r_cnt <= r_cnt + 1'b1;
                                    r_sorted <= 1'b0;
                                    r_ok <= 1'b1;
                                end
                            end
                            MODE_QUERY, MODE_SORT: r_ok <= 1'b1;
                            MODE_CLEAR: begin
                                r_cnt <= '0;
                                r_ok <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN_RD: ;
                ST_SCAN_CHK: begin
                    if (i_rdata == r_val) begin
                        r_freq <= r_freq + 1'b1;
                        if (!r_fnd) begin
                            r_fnd <= 1'b1;
                            r_pos <= r_i;
                        end
                    end
                    r_i <= r_i + 1'b1;
                end
                ST_REM_WT: begin
                    r_cnt <= r_cnt - 1'b1;
                    r_sorted <= 1'b0;
                    r_ok <= 1'b1;
                end
                ST_SORT_RD0: begin
                    if (r_i + 1'b1 >= r_lim) begin
                        if (r_lim > CNT_W'(1) && r_swapped) begin
                            r_lim <= r_lim - 1'b1;
                            r_i <= '0;
                            r_swapped <= 1'b0;
                        end else begin
                            r_sorted <= 1'b1;
                        end
                    end
                end
                ST_SORT_RD1: r_a <= i_rdata;
                ST_SORT_CMP: begin
                    if (r_a > i_rdata) begin
                        r_swapped <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_SORT_WR: r_i <= r_i + 1'b1;
                ST_BS_RD: begin
                    if (r_sorted) begin
                        r_ok <= 1'b1;
                        r_pos <= (r_lo < r_hi) ? w_mid : r_lo;
                    end
                end
                ST_BS_WT: begin
                    if (i_rdata < r_val) begin
                        r_lo <= r_pos + 1'b1;
                    end else begin
                        r_hi <= r_pos;
                    end
                end
                ST_BS_CHK: begin
                    if (r_pos < r_cnt && i_rdata == r_val) begin
                        r_fnd <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!r_vld || i_res_ready) begin
                        r_vld <= 1'b1;
                        r_res.op_ok <= r_ok;
                        r_res.found <= r_fnd && r_mode != MODE_REMOVE;
                        r_res.found_index <= (r_fnd && r_mode != MODE_REMOVE)
                                             ? r_pos[IDX_W-1:0] : '0;
                        r_res.frequency <= (r_mode == MODE_QUERY) ? r_freq : '0;
                        r_res.item_count <= r_cnt;
                        r_res.is_empty <= r_cnt == '0;
                        r_res.is_sorted <= r_sorted;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY)) else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> r_vld) else $error("result lost");
endmodule

// File: test/unordered_bag_with_sort_and_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unordered_bag_with_sort_and_search_core_tb
// Self-checking bench for the bag core. A directed table and a fill sequence cover reset
// status, full and empty bags, every mode, duplicates and unused modes;
// random command sequences follow under several idling phases and one long
// output stall. Every result beat is compared with a behavioral bag model.
// ----------------------------------------------------------------------------
module unordered_bag_with_sort_and_search_core_tb import ubag_pkg::*;;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] val;
        bit          fixed;
        t_result     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   long_hold;
    bit   hold_done = 1'b0;
    int   hold_cycles = 0;
    int   beats_out;
    int   searches_hit;

    logic [31:0] bag_mem [CAPACITY];
    int          bag_cnt;
    bit          bag_sorted;
    t_result     pending_q[$];

    ubag_in_if  cmd_if ();
    ubag_out_if res_if ();

    unordered_bag_with_sort_and_search_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #1s;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_result bag_apply(logic [2:0] mode, logic [31:0] v);
        t_result     r;
        int          p;
        int          lo;
        int          hi;
        int          mid;
        logic [31:0] t;
        r = '0;
        p = -1;
        case (mode)
            MODE_ADD: begin
                if (bag_cnt < CAPACITY) begin
                    bag_mem[bag_cnt] = v;
                    bag_cnt++;
                    bag_sorted = 1'b0;
                    r.op_ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                for (int i = bag_cnt - 1; i >= 0; i--) if (bag_mem[i] == v) p = i;
                if (p >= 0) begin
                    bag_cnt--;
                    bag_mem[p] = bag_mem[bag_cnt];
                    bag_sorted = 1'b0;
                    r.op_ok = 1'b1;
                end
            end
            MODE_QUERY: begin
                r.op_ok = 1'b1;
                for (int i = bag_cnt - 1; i >= 0; i--) begin
                    if (bag_mem[i] == v) begin
                        p = i;
                        r.frequency++;
                    end
                end
                if (p >= 0) begin
                    r.found = 1'b1;
                    r.found_index = IDX_W'(p);
                end
            end
            MODE_SORT: begin
                for (int ps = 0; ps + 1 < bag_cnt; ps++) begin
                    for (int k = 0; k + 1 < bag_cnt - ps; k++) begin
                        if (bag_mem[k] > bag_mem[k+1]) begin
                            t = bag_mem[k];
                            bag_mem[k] = bag_mem[k+1];
                            bag_mem[k+1] = t;
                        end
                    end
                end
                bag_sorted = 1'b1;
                r.op_ok = 1'b1;
            end
            MODE_SEARCH: begin
                if (bag_sorted) begin
                    r.op_ok = 1'b1;
                    lo = 0;
                    hi = bag_cnt;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (bag_mem[mid] < v) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo < bag_cnt && bag_mem[lo] == v) begin
                        r.found = 1'b1;
                        r.found_index = IDX_W'(lo);
                        searches_hit++;
                    end
                end
            end
            MODE_CLEAR: begin
                bag_cnt = 0;
                r.op_ok = 1'b1;
            end
            default: ;
        endcase
        r.item_count = CNT_W'(bag_cnt);
        r.is_empty = (bag_cnt == 0);
        r.is_sorted = bag_sorted;
        return r;
    endfunction

    task automatic send_beat(logic [2:0] mode, logic [31:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= mode;
        cmd_if.item_value <= v;
        @(posedge i_clk iff cmd_if.ready);
        pending_q = {pending_q, bag_apply(mode, v)};
    endtask

    task automatic send_expect(logic [2:0] mode, logic [31:0] v, t_result want);
        t_result got_pred;
        send_beat(mode, v);
        got_pred = pending_q[$];
        if (got_pred != want) begin
            $error("directed row mode %0d: table %h, model %h", mode, want, got_pred);
            errors++;
        end
    endtask

    function automatic t_result mk(bit ok, bit fnd, int idx, int freq, int cnt, bit srt);
        t_result r;
        r.op_ok = ok;
        r.found = fnd;
        r.found_index = IDX_W'(idx);
        r.frequency = CNT_W'(freq);
        r.item_count = CNT_W'(cnt);
        r.is_empty = (cnt == 0);
        r.is_sorted = srt;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return bag_cnt > 0 ? bag_mem[$urandom_range(bag_cnt - 1)] : 32'd0;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFF0 + $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 40) return MODE_ADD;
        if (r < 55) return MODE_REMOVE;
        if (r < 70) return MODE_QUERY;
        if (r < 77) return MODE_SORT;
        if (r < 93) return MODE_SEARCH;
        if (r < 95) return MODE_CLEAR;
        return 3'(3'd6 + $urandom_range(1));
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            beats_out++;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (res_if.op_ok !== want.op_ok) begin
                    $error("op_ok exp %0d got %0d", want.op_ok, res_if.op_ok); errors++;
                end
                if (res_if.found !== want.found) begin
                    $error("found exp %0d got %0d", want.found, res_if.found); errors++;
                end
                if (res_if.found_index !== want.found_index) begin
                    $error("found_index exp %0d got %0d", want.found_index,
                           res_if.found_index);
                    errors++;
                end
                if (res_if.frequency !== want.frequency) begin
                    $error("frequency exp %0d got %0d", want.frequency, res_if.frequency);
                    errors++;
                end
                if (res_if.item_count !== want.item_count) begin
                    $error("item_count exp %0d got %0d", want.item_count,
                           res_if.item_count);
                    errors++;
                end
                if (res_if.is_empty !== want.is_empty) begin
                    $error("is_empty exp %0d got %0d", want.is_empty, res_if.is_empty);
                    errors++;
                end
                if (res_if.is_sorted !== want.is_sorted) begin
                    $error("is_sorted exp %0d got %0d", want.is_sorted, res_if.is_sorted);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (long_hold && !hold_done) begin
            hold_done <= 1'b1;
            hold_cycles <= 3000;
            res_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        t_row rows[$];
        int   wait_n;
        errors = 0;
        beats_out = 0;
        searches_hit = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        bag_cnt = 0;
        bag_sorted = 1'b0;
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.mode = MODE_ADD;
        cmd_if.item_value = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{MODE_QUERY,  32'd5,          1, mk(1, 0, 0, 0, 0, 0)},
            '{MODE_SEARCH, 32'd5,          1, mk(0, 0, 0, 0, 0, 0)},
            '{MODE_REMOVE, 32'd5,          1, mk(0, 0, 0, 0, 0, 0)},
            '{MODE_SORT,   32'd0,          1, mk(1, 0, 0, 0, 0, 1)},
            '{MODE_SEARCH, 32'd0,          1, mk(1, 0, 0, 0, 0, 1)},
            '{MODE_ADD,    32'hFFFF_FFFF,  1, mk(1, 0, 0, 0, 1, 0)},
            '{MODE_ADD,    32'd0,          1, mk(1, 0, 0, 0, 2, 0)},
            '{MODE_ADD,    32'hAAAA_5555,  0, '0},
            '{MODE_ADD,    32'd0,          0, '0},
            '{MODE_SEARCH, 32'd0,          1, mk(0, 0, 0, 0, 4, 0)},
            '{MODE_QUERY,  32'd0,          1, mk(1, 1, 1, 2, 4, 0)},
            '{MODE_SORT,   32'd0,          0, '0},
            '{MODE_SEARCH, 32'd0,          1, mk(1, 1, 0, 0, 4, 1)},
            '{MODE_SEARCH, 32'hFFFF_FFFF,  1, mk(1, 1, 3, 0, 4, 1)},
            '{MODE_SEARCH, 32'h5555_AAAA,  1, mk(1, 0, 0, 0, 4, 1)},
            '{MODE_REMOVE, 32'd0,          0, '0},
            '{3'd6,        32'd1,          1, mk(0, 0, 0, 0, 3, 0)},
            '{3'd7,        32'hFFFF_FFFF,  1, mk(0, 0, 0, 0, 3, 0)},
            '{MODE_CLEAR,  32'd0,          1, mk(1, 0, 0, 0, 0, 0)},
            '{MODE_QUERY,  32'd0,          1, mk(1, 0, 0, 0, 0, 0)}
        };
        foreach (rows[i]) begin
            if (rows[i].fixed) send_expect(rows[i].mode, rows[i].val, rows[i].res);
            else send_beat(rows[i].mode, rows[i].val);
        end
        for (int i = 0; i < CAPACITY; i++) send_beat(MODE_ADD, 32'd1000 - i);
        send_expect(MODE_ADD, 32'd7, mk(0, 0, 0, 0, CAPACITY, 0));
        send_beat(MODE_SORT, 32'd0);
        send_expect(MODE_SEARCH, 32'd937, mk(1, 1, 0, 0, CAPACITY, 1));
        send_expect(MODE_SEARCH, 32'd1000, mk(1, 1, CAPACITY - 1, 0, CAPACITY, 1));
        send_beat(MODE_CLEAR, 32'd0);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1'b1; end
            endcase
            for (int n = 0; n < 240; n++) send_beat(pick_mode(), pick_value());
        end
        cmd_if.valid <= 1'b0;
        recv_stall_pct = 0;

        wait_n = 0;
        while (pending_q.size() != 0 && wait_n < 100000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (50) @(posedge i_clk);
        $display("Checked %0d result beats over five idling phases, %0d search hits.",
                 beats_out, searches_hit);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/ubag_pkg.sv
hdl/ubag_if.sv
hdl/ubag_ram.sv
hdl/ubag_ctrl.sv
hdl/unordered_bag_with_sort_and_search_core.sv
test/unordered_bag_with_sort_and_search_core_tb.sv
